[rtl/assert_macros.svh]
// Assertion macros for the placement clearance check unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[rtl/pcc_pkg.sv]
// ---------------------------------------------------------------------------
// pcc_pkg
// Types and constants shared by the placement clearance check unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package pcc_pkg;
   localparam int MaxExclusions = 256;
   localparam int MaxRoutes     = 256;
   localparam int ExclAw = $clog2(MaxExclusions);
   localparam int RouteAw = $clog2(MaxRoutes);
   localparam int ExclCw = $clog2(MaxExclusions + 1);
   localparam int RouteCw = $clog2(MaxRoutes + 1);

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_EXCL  = 2'd1;
   localparam logic [1:0] ACT_ROUTE = 2'd2;
   localparam logic [1:0] ACT_QUERY = 2'd3;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_RANGE  = 3'd1;
   localparam logic [2:0] ST_FULL   = 3'd2;
   localparam logic [2:0] ST_MASK   = 3'd3;
   localparam logic [2:0] ST_LENGTH = 3'd4;

   localparam logic CSR_AGENT0 = 1'b0;
   localparam logic CSR_AGENT1 = 1'b1;

   localparam logic [14:0] SizeMax = 15'd16384;
   localparam logic [14:0] ExclMin = 15'd26;
   localparam logic [41:0] Window  = 42'd524288;
   localparam logic [41:0] SegMax  = 42'd131072;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [39:0] point_x;
      logic signed [39:0] point_z;
      logic signed [39:0] end_x;
      logic signed [39:0] end_z;
      logic [14:0]        size_value;
      logic [1:0]         agent_mask;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic [2:0] status;
      logic [8:0] exclusion_count;
      logic [8:0] route_count;
   } rsp_type;

   typedef struct packed {
      logic signed [39:0] x;
      logic signed [39:0] z;
      logic [14:0]        radius;
   } excl_type;

   typedef struct packed {
      logic signed [39:0] sx;
      logic signed [39:0] sz;
      logic signed [39:0] ex;
      logic signed [39:0] ez;
      logic [14:0]        lane_radius;
      logic [1:0]         agents;
   } route_type;

   // request to the shared multiply-accumulate unit
   typedef struct packed {
      logic        start;
      logic        clear;
      logic        negate;
      logic [63:0] a;
      logic [63:0] b;
   } mac_cmd_type;
endpackage

[rtl/pcc_mac.sv]
// ---------------------------------------------------------------------------
// pcc_mac
// Shared 128-bit signed multiply-accumulate, 32x32 partial product a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pcc_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  pcc_pkg::mac_cmd_type  cmd,
   output logic                  busy,
   output logic signed [127:0]   acc
);
   logic [1:0]          step_ff, step_in;
   logic                busy_ff, busy_in;
   logic [63:0]         a_ff, a_in, b_ff, b_in;
   logic                neg_ff, neg_in;
   logic [127:0]        part_ff, part_in;
   logic signed [127:0] acc_ff, acc_in;
   logic [31:0]         ah, bh;
   logic [63:0]         pp;
   logic [127:0]        shifted, next_part;

   always_comb begin
      ah = step_ff[1] ? a_ff[63:32] : a_ff[31:0];
      bh = step_ff[0] ? b_ff[63:32] : b_ff[31:0];
      pp = 64'(ah) * 64'(bh);
      shifted = 128'(pp) << (7'(step_ff[0] + step_ff[1]) * 7'd32);
      next_part = part_ff + shifted;
      step_in = step_ff;
      busy_in = busy_ff;
      a_in = a_ff;
      b_in = b_ff;
      neg_in = neg_ff;
      part_in = part_ff;
      acc_in = cmd.clear ? '0 : acc_ff;
      if (busy_ff) begin
         part_in = next_part;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            acc_in = neg_ff ? acc_in - $signed(next_part) : acc_in + $signed(next_part);
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         a_in = cmd.a;
         b_in = cmd.b;
         neg_in = cmd.negate;
         part_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      neg_ff <= neg_in;
      part_ff <= part_in;
      acc_ff <= acc_in;
   end

   assign busy = busy_ff;
   assign acc = acc_ff;
endmodule

[rtl/pcc_tables.sv]
// ---------------------------------------------------------------------------
// pcc_tables
// Exclusion and route memories, one write and one registered read each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pcc_tables (
   input  logic                            clock,
   input  logic                            excl_we,
   input  logic [pcc_pkg::ExclAw-1:0]      excl_addr,
   input  pcc_pkg::excl_type               excl_wdata,
   output pcc_pkg::excl_type               excl_rdata,
   input  logic                            route_we,
   input  logic [pcc_pkg::RouteAw-1:0]     route_addr,
   input  pcc_pkg::route_type              route_wdata,
   output pcc_pkg::route_type              route_rdata
);
   pcc_pkg::excl_type  excl_mem [pcc_pkg::MaxExclusions];
   pcc_pkg::route_type route_mem [pcc_pkg::MaxRoutes];
   pcc_pkg::excl_type  excl_rd_ff;
   pcc_pkg::route_type route_rd_ff;

   always_ff @(posedge clock) begin
      if (excl_we) excl_mem[excl_addr] <= excl_wdata;
      excl_rd_ff <= excl_mem[excl_addr];
   end

   always_ff @(posedge clock) begin
      if (route_we) route_mem[route_addr] <= route_wdata;
      route_rd_ff <= route_mem[route_addr];
   end

   assign excl_rdata = excl_rd_ff;
   assign route_rdata = route_rd_ff;
endmodule

[rtl/placement_clearance_check_unit.sv]
// ---------------------------------------------------------------------------
// placement_clearance_check_unit
// Circle and segment clearance test over stored exclusions and routes.
// ---------------------------------------------------------------------------
// Input transfers on req_valid/req_stall carry one action: clear, add
// exclusion, add route or query. Each gives exactly one response transfer
// on rsp_valid/rsp_stall with allowed, status and both table counts.
// req_stall is high while an item is in work or its response is held.
// Clear and add exclusion use no multiplier; a route add runs two products
// on the shared multiplier. A query visits stored entries until the first
// hit: an exclusion out of reach is skipped before any product, and the
// time spent on each entry is set by the one 32x32 multiplier that builds
// every 64x64 product in four steps.
// Reset empties both tables (counts to zero), restores agent radii to 128
// and drops any response. Table contents are not cleared. A stalled
// response holds until taken; no new item is taken meanwhile.
// csr_ writes set agent radii and may be written only while idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module placement_clearance_check_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pcc_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pcc_pkg::rsp_type     rsp_data,
   input  logic                 csr_write_enable,
   input  logic                 csr_index,
   input  logic [10:0]          csr_write_data
);
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DECODE = 5'd1;
   localparam logic [4:0] S_RL1   = 5'd2;
   localparam logic [4:0] S_RL2   = 5'd3;
   localparam logic [4:0] S_RL3   = 5'd4;
   localparam logic [4:0] S_ENEXT = 5'd5;
   localparam logic [4:0] S_EWAIT = 5'd6;
   localparam logic [4:0] S_EM1   = 5'd7;
   localparam logic [4:0] S_EM2   = 5'd8;
   localparam logic [4:0] S_EM3   = 5'd9;
   localparam logic [4:0] S_RNEXT = 5'd10;
   localparam logic [4:0] S_RWAIT = 5'd11;
   localparam logic [4:0] S_RP1   = 5'd12;
   localparam logic [4:0] S_RP2   = 5'd13;
   localparam logic [4:0] S_RP3   = 5'd14;
   localparam logic [4:0] S_RD1   = 5'd15;
   localparam logic [4:0] S_RD2   = 5'd16;
   localparam logic [4:0] S_RD3   = 5'd17;
   localparam logic [4:0] S_RCASE = 5'd18;
   localparam logic [4:0] S_RC1   = 5'd19;
   localparam logic [4:0] S_RC2   = 5'd20;
   localparam logic [4:0] S_RC3   = 5'd21;
   localparam logic [4:0] S_RR    = 5'd22;
   localparam logic [4:0] S_RCMP  = 5'd23;
   localparam logic [4:0] S_DONE  = 5'd24;
   localparam logic [4:0] S_RE1   = 5'd25;
   localparam logic [4:0] S_RE2   = 5'd26;
   localparam logic [4:0] S_RM    = 5'd27;

   logic [4:0]  state_ff, state_in;
   logic [10:0] agent0_ff, agent0_in, agent1_ff, agent1_in;
   logic [pcc_pkg::ExclCw-1:0]  excl_cnt_ff, excl_cnt_in;
   logic [pcc_pkg::RouteCw-1:0] route_cnt_ff, route_cnt_in;
   logic [pcc_pkg::ExclCw-1:0]  eidx_ff, eidx_in;
   logic [pcc_pkg::RouteCw-1:0] ridx_ff, ridx_in;
   pcc_pkg::req_type req_ff, req_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pcc_pkg::rsp_type rsp_ff, rsp_in;
   logic        hit_ff, hit_in;
   logic signed [127:0] t1_ff, t1_in, t2_ff, t2_in;
   logic [63:0] r_ff, r_in;
   logic signed [41:0] ax_ff, ax_in, az_ff, az_in, dx_ff, dx_in, dz_ff, dz_in;

   pcc_pkg::mac_cmd_type cmd;
   logic                 mac_busy;
   logic signed [127:0]  acc;

   logic excl_we, route_we;
   logic [pcc_pkg::ExclAw-1:0]  excl_addr;
   logic [pcc_pkg::RouteAw-1:0] route_addr;
   pcc_pkg::excl_type  excl_wdata, excl_rdata;
   pcc_pkg::route_type route_wdata, route_rdata;

   logic signed [41:0] rdx, rdz, qdx, qdz, ex_s, ez_s;
   logic [41:0] mrdx, mrdz, mqdx, mqdz;
   logic [10:0] agent_sel;
   logic [16:0] rsum;

   function automatic logic [41:0] mag42(input logic signed [41:0] v);
      mag42 = v[41] ? 42'(-v) : 42'(v);
   endfunction

   pcc_mac u_mac (
      .clock (clock), .reset (reset), .cmd (cmd), .busy (mac_busy), .acc (acc)
   );

   pcc_tables u_tables (
      .clock (clock),
      .excl_we (excl_we), .excl_addr (excl_addr),
      .excl_wdata (excl_wdata), .excl_rdata (excl_rdata),
      .route_we (route_we), .route_addr (route_addr),
      .route_wdata (route_wdata), .route_rdata (route_rdata)
   );

   always_comb begin
      rdx = 42'(req_ff.end_x) - 42'(req_ff.point_x);
      rdz = 42'(req_ff.end_z) - 42'(req_ff.point_z);
      mrdx = mag42(rdx);
      mrdz = mag42(rdz);
      qdx = 42'(excl_rdata.x) - 42'(req_ff.point_x);
      qdz = 42'(excl_rdata.z) - 42'(req_ff.point_z);
      mqdx = mag42(qdx);
      mqdz = mag42(qdz);
      ex_s = ax_ff + dx_ff;
      ez_s = az_ff + dz_ff;
      agent_sel = 11'd0;
      if (route_rdata.agents[0] && agent0_ff > agent_sel) agent_sel = agent0_ff;
      if (route_rdata.agents[1] && agent1_ff > agent_sel) agent_sel = agent1_ff;
      rsum = 17'(route_rdata.lane_radius) + 17'(agent_sel) + 17'(req_ff.size_value);
   end

   always_comb begin
      state_in = state_ff;
      agent0_in = agent0_ff;
      agent1_in = agent1_ff;
      excl_cnt_in = excl_cnt_ff;
      route_cnt_in = route_cnt_ff;
      eidx_in = eidx_ff;
      ridx_in = ridx_ff;
      req_in = req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      hit_in = hit_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      r_in = r_ff;
      ax_in = ax_ff;
      az_in = az_ff;
      dx_in = dx_ff;
      dz_in = dz_ff;
      cmd = '0;
      excl_we = 1'b0;
      route_we = 1'b0;
      excl_addr = eidx_ff[pcc_pkg::ExclAw-1:0];
      route_addr = ridx_ff[pcc_pkg::RouteAw-1:0];
      excl_wdata.x = req_ff.point_x;
      excl_wdata.z = req_ff.point_z;
      excl_wdata.radius = req_ff.size_value;
      route_wdata.sx = req_ff.point_x;
      route_wdata.sz = req_ff.point_z;
      route_wdata.ex = req_ff.end_x;
      route_wdata.ez = req_ff.end_z;
      route_wdata.lane_radius = req_ff.size_value;
      route_wdata.agents = req_ff.agent_mask;

      if (csr_write_enable) begin
         unique case (csr_index)
            pcc_pkg::CSR_AGENT0: agent0_in = csr_write_data;
            pcc_pkg::CSR_AGENT1: agent1_in = csr_write_data;
            default: ;
         endcase
      end
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               req_in = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            rsp_in.allowed = 1'b0;
            rsp_in.status = pcc_pkg::ST_OK;
            state_in = S_DONE;
            unique case (req_ff.action)
               pcc_pkg::ACT_CLEAR: begin
                  excl_cnt_in = '0;
                  route_cnt_in = '0;
               end
               pcc_pkg::ACT_EXCL: begin
                  excl_addr = excl_cnt_ff[pcc_pkg::ExclAw-1:0];
                  if (req_ff.size_value < pcc_pkg::ExclMin ||
                      req_ff.size_value > pcc_pkg::SizeMax)
                     rsp_in.status = pcc_pkg::ST_RANGE;
                  else if (excl_cnt_ff >= pcc_pkg::ExclCw'(pcc_pkg::MaxExclusions))
                     rsp_in.status = pcc_pkg::ST_FULL;
                  else begin
                     excl_we = 1'b1;
                     excl_cnt_in = excl_cnt_ff + 1'b1;
                  end
               end
               pcc_pkg::ACT_ROUTE: begin
                  if (req_ff.size_value > pcc_pkg::SizeMax)
                     rsp_in.status = pcc_pkg::ST_RANGE;
                  else if (req_ff.agent_mask == 2'd0)
                     rsp_in.status = pcc_pkg::ST_MASK;
                  else if (mrdx > pcc_pkg::SegMax || mrdz > pcc_pkg::SegMax)
                     rsp_in.status = pcc_pkg::ST_LENGTH;
                  else begin
                     cmd.start = 1'b1;
                     cmd.clear = 1'b1;
                     cmd.a = 64'(mrdx);
                     cmd.b = 64'(mrdx);
                     state_in = S_RL1;
                  end
               end
               default: begin
                  if (req_ff.size_value > pcc_pkg::SizeMax)
                     rsp_in.status = pcc_pkg::ST_RANGE;
                  else begin
                     hit_in = 1'b0;
                     eidx_in = '0;
                     ridx_in = '0;
                     state_in = S_ENEXT;
                  end
               end
            endcase
         end
         S_RL1: if (!mac_busy) begin
            cmd.start = 1'b1;
            cmd.a = 64'(mrdz);
            cmd.b = 64'(mrdz);
            state_in = S_RL2;
         end
         S_RL2: if (!mac_busy) state_in = S_RL3;
         S_RL3: begin
            state_in = S_DONE;
            // below 0.01 m means a squared length of 6 or less
            if (acc < 128'sd7 ||
                acc > 128'sd17179869184)
               rsp_in.status = pcc_pkg::ST_LENGTH;
            else if (route_cnt_ff >= pcc_pkg::RouteCw'(pcc_pkg::MaxRoutes))
               rsp_in.status = pcc_pkg::ST_FULL;
            else begin
               route_addr = route_cnt_ff[pcc_pkg::RouteAw-1:0];
               route_we = 1'b1;
               route_cnt_in = route_cnt_ff + 1'b1;
            end
         end
         S_ENEXT: begin
            if (hit_ff || eidx_ff >= excl_cnt_ff) state_in = S_RNEXT;
            else state_in = S_EWAIT;
         end
         S_EWAIT: begin
            if (mqdx > pcc_pkg::Window || mqdz > pcc_pkg::Window) begin
               eidx_in = eidx_ff + 1'b1;
               state_in = S_ENEXT;
            end else begin
               r_in = 64'(excl_rdata.radius) + 64'(req_ff.size_value);
               cmd.start = 1'b1;
               cmd.clear = 1'b1;
               cmd.a = 64'(mqdx);
               cmd.b = 64'(mqdx);
               state_in = S_EM1;
            end
         end
         S_EM1: if (!mac_busy) begin
            cmd.start = 1'b1;
            cmd.a = 64'(mqdz);
            cmd.b = 64'(mqdz);
            state_in = S_EM2;
         end
         S_EM2: if (!mac_busy) begin
            cmd.start = 1'b1;
            cmd.negate = 1'b1;
            cmd.a = r_ff;
            cmd.b = r_ff;
            state_in = S_EM3;
         end
         S_EM3: if (!mac_busy) begin
            if (acc <= 0) hit_in = 1'b1;
            eidx_in = eidx_ff + 1'b1;
            state_in = S_ENEXT;
         end
         S_RNEXT: begin
            if (hit_ff || ridx_ff >= route_cnt_ff) state_in = S_DONE;
            else state_in = S_RWAIT;
         end
         S_RWAIT: begin
            ax_in = 42'(route_rdata.sx) - 42'(req_ff.point_x);
            az_in = 42'(route_rdata.sz) - 42'(req_ff.point_z);
            dx_in = 42'(route_rdata.ex) - 42'(route_rdata.sx);
            dz_in = 42'(route_rdata.ez) - 42'(route_rdata.sz);
            r_in = 64'(rsum);
            if (mag42(ax_in) > pcc_pkg::Window || mag42(az_in) > pcc_pkg::Window) begin
               ridx_in = ridx_ff + 1'b1;
               state_in = S_RNEXT;
            end else state_in = S_RP1;
         end
         S_RP1: if (!mac_busy) begin
            cmd.start = 1'b1;
            cmd.clear = 1'b1;
            cmd.negate = !(ax_ff[41] ^ dx_ff[41]);
            cmd.a = 64'(mag42(ax_ff));
            cmd.b = 64'(mag42(dx_ff));
            state_in = S_RP2;
         end
         S_RP2: if (!mac_busy) begin
            cmd.start = 1'b1;
            cmd.negate = !(az_ff[41] ^ dz_ff[41]);
            cmd.a = 64'(mag42(az_ff));
            cmd.b = 64'(mag42(dz_ff));
            state_in = S_RP3;
         end
         S_RP3: if (!mac_busy) begin
            t1_in = acc;
            cmd.start = 1'b1;
            cmd.clear = 1'b1;
            cmd.a = 64'(mag42(dx_ff));
            cmd.b = 64'(mag42(dx_ff));
            state_in = S_RD1;
         end
         S_RD1: if (!mac_busy) begin
            cmd.start = 1'b1;
            cmd.a = 64'(mag42(dz_ff));
            cmd.b = 64'(mag42(dz_ff));
            state_in = S_RD2;
         end
         S_RD2: if (!mac_busy) state_in = S_RD3;
         S_RD3: begin
            t2_in = acc;
            state_in = S_RCASE;
         end
         S_RCASE: begin
            cmd.start = 1'b1;
            cmd.clear = 1'b1;
            if (t1_ff <= 0) begin
               cmd.a = 64'(mag42(ax_ff));
               cmd.b = 64'(mag42(ax_ff));
               state_in = S_RE1;
            end else if (t1_ff >= t2_ff) begin
               ax_in = ex_s;
               az_in = ez_s;
               cmd.a = 64'(mag42(ex_s));
               cmd.b = 64'(mag42(ex_s));
               state_in = S_RE1;
            end else begin
               cmd.negate = ax_ff[41] ^ dz_ff[41];
               cmd.a = 64'(mag42(ax_ff));
               cmd.b = 64'(mag42(dz_ff));
               state_in = S_RC1;
            end
         end
         S_RE1: if (!mac_busy) begin
            cmd.start = 1'b1;
            cmd.a = 64'(mag42(az_ff));
            cmd.b = 64'(mag42(az_ff));
            state_in = S_RE2;
         end
         S_RE2: if (!mac_busy) begin
            cmd.start = 1'b1;
            cmd.negate = 1'b1;
            cmd.a = r_ff;
            cmd.b = r_ff;
            state_in = S_RCMP;
         end
         S_RC1: if (!mac_busy) begin
            cmd.start = 1'b1;
            cmd.negate = !(az_ff[41] ^ dx_ff[41]);
            cmd.a = 64'(mag42(az_ff));
            cmd.b = 64'(mag42(dx_ff));
            state_in = S_RC2;
         end
         S_RC2: if (!mac_busy) begin
            t1_in = acc;
            cmd.start = 1'b1;
            cmd.clear = 1'b1;
            cmd.a = r_ff;
            cmd.b = r_ff;
            state_in = S_RC3;
         end
         S_RC3: if (!mac_busy) begin
            // cross product magnitude fits 64 bits
            r_in = t1_ff[63] ? 64'(-t1_ff) : t1_ff[63:0];
            t1_in = acc;
            state_in = S_RR;
         end
         S_RR: begin
            // cross^2 - r^2 * len^2 using two 64-bit products
            cmd.start = 1'b1;
            cmd.clear = 1'b1;
            cmd.a = r_ff;
            cmd.b = r_ff;
            state_in = S_RM;
         end
         S_RCMP: if (!mac_busy) begin
            if (acc <= 0) hit_in = 1'b1;
            ridx_in = ridx_ff + 1'b1;
            state_in = S_RNEXT;
         end
         S_DONE: begin
            rsp_in.allowed = (req_ff.action == pcc_pkg::ACT_QUERY) &&
                             (rsp_ff.status == pcc_pkg::ST_OK) && !hit_ff;
            rsp_in.exclusion_count = 9'(excl_cnt_ff);
            rsp_in.route_count = 9'(route_cnt_ff);
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_RM: if (!mac_busy) begin
            // r^2 * len^2 from the low 64-bit words (t1 is r^2, t2 is len^2)
            cmd.start = 1'b1;
            cmd.negate = 1'b1;
            cmd.a = t1_ff[63:0];
            cmd.b = t2_ff[63:0];
            state_in = S_RCMP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         agent0_ff <= 11'd128;
         agent1_ff <= 11'd128;
         excl_cnt_ff <= '0;
         route_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         agent0_ff <= agent0_in;
         agent1_ff <= agent1_in;
         excl_cnt_ff <= excl_cnt_in;
         route_cnt_ff <= route_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff <= hit_in;
      end
      eidx_ff <= eidx_in;
      ridx_ff <= ridx_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      r_ff <= r_in;
      ax_ff <= ax_in;
      az_ff <= az_in;
      dx_ff <= dx_in;
      dz_ff <= dz_in;
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_IMPL(a_cnt_excl, clock, reset, 1'b1,
      excl_cnt_ff <= pcc_pkg::ExclCw'(pcc_pkg::MaxExclusions), "exclusion count overflow")
   `ASSERT_IMPL(a_cnt_route, clock, reset, 1'b1,
      route_cnt_ff <= pcc_pkg::RouteCw'(pcc_pkg::MaxRoutes), "route count overflow")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled response changed")
   `ASSERT_IMPL(a_allow_q, clock, reset, rsp_valid && rsp_data.allowed,
      rsp_data.status == pcc_pkg::ST_OK, "allowed with error status")
endmodule

[dv/tb_placement_clearance_check_unit.sv]
// ---------------------------------------------------------------------------
// tb_placement_clearance_check_unit
// Self-checking bench for the placement clearance check unit.
// ---------------------------------------------------------------------------
// Every input transfer is fed to a cycle-free copy of the clearance tables,
// which works out the response. Each response transfer is checked field by
// field against the oldest predicted one. Directed items cover range limits,
// every status and both full tables. Random items then build clusters of
// exclusions and routes around shared centres and query close to them,
// across several agent radius settings. Both handshakes idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_placement_clearance_check_unit;

   localparam int WatchdogLimit = 200000;

   class clearance_scoreboard;
      longint exc_x[pcc_pkg::MaxExclusions], exc_z[pcc_pkg::MaxExclusions];
      longint exc_r[pcc_pkg::MaxExclusions];
      longint rt_sx[pcc_pkg::MaxRoutes], rt_sz[pcc_pkg::MaxRoutes];
      longint rt_ex[pcc_pkg::MaxRoutes], rt_ez[pcc_pkg::MaxRoutes];
      longint rt_hw[pcc_pkg::MaxRoutes];
      logic [1:0] rt_agents[pcc_pkg::MaxRoutes];
      int n_excl, n_route;
      longint radius0, radius1;
      pcc_pkg::rsp_type pending[$];
      int mismatches, queries, clear_queries;
      int status_seen[5];

      function void reset_state();
         n_excl = 0;
         n_route = 0;
         radius0 = 128;
         radius1 = 128;
      endfunction

      function void set_radius(logic idx, logic [10:0] value);
         if (idx == pcc_pkg::CSR_AGENT0) radius0 = value;
         else radius1 = value;
      endfunction

      function longint mag(longint v);
         return v < 0 ? -v : v;
      endfunction

      function bit excl_hit(int i, longint px, longint pz, longint foot);
         longint dx, dz, r;
         dx = exc_x[i] - px;
         dz = exc_z[i] - pz;
         if (mag(dx) > pcc_pkg::Window || mag(dz) > pcc_pkg::Window) return 0;
         r = exc_r[i] + foot;
         return dx * dx + dz * dz <= r * r;
      endfunction

      function bit route_hit(int i, longint px, longint pz, longint foot);
         longint ax, az, dx, dz, p, d2, agent, r, r2, ex, ez, c;
         logic [127:0] c2, lim;
         ax = rt_sx[i] - px;
         az = rt_sz[i] - pz;
         dx = rt_ex[i] - rt_sx[i];
         dz = rt_ez[i] - rt_sz[i];
         if (mag(ax) > pcc_pkg::Window || mag(az) > pcc_pkg::Window) return 0;
         agent = 0;
         if (rt_agents[i][0] && radius0 > agent) agent = radius0;
         if (rt_agents[i][1] && radius1 > agent) agent = radius1;
         r = rt_hw[i] + agent + foot;
         r2 = r * r;
         p = -(ax * dx + az * dz);
         d2 = dx * dx + dz * dz;
         if (p <= 0) return ax * ax + az * az <= r2;
         if (p >= d2) begin
            ex = ax + dx;
            ez = az + dz;
            return ex * ex + ez * ez <= r2;
         end
         c = mag(ax * dz - az * dx);
         c2 = 128'(c) * 128'(c);
         lim = 128'(r2) * 128'(d2);
         return c2 <= lim;
      endfunction

      function void note_request(pcc_pkg::req_type q);
         pcc_pkg::rsp_type o;
         longint px, pz, ex, ez, dx, dz, sz, l2;
         bit ok;
         px = longint'(q.point_x);
         pz = longint'(q.point_z);
         ex = longint'(q.end_x);
         ez = longint'(q.end_z);
         sz = q.size_value;
         o = '0;
         o.status = pcc_pkg::ST_OK;
         case (q.action)
            pcc_pkg::ACT_CLEAR: begin
               n_excl = 0;
               n_route = 0;
            end
            pcc_pkg::ACT_EXCL: begin
               if (sz < pcc_pkg::ExclMin || sz > pcc_pkg::SizeMax)
                  o.status = pcc_pkg::ST_RANGE;
               else if (n_excl >= pcc_pkg::MaxExclusions) o.status = pcc_pkg::ST_FULL;
               else begin
                  exc_x[n_excl] = px;
                  exc_z[n_excl] = pz;
                  exc_r[n_excl] = sz;
                  n_excl++;
               end
            end
            pcc_pkg::ACT_ROUTE: begin
               dx = ex - px;
               dz = ez - pz;
               if (sz > pcc_pkg::SizeMax) o.status = pcc_pkg::ST_RANGE;
               else if (q.agent_mask == 2'b00) o.status = pcc_pkg::ST_MASK;
               else if (mag(dx) > pcc_pkg::SegMax || mag(dz) > pcc_pkg::SegMax)
                  o.status = pcc_pkg::ST_LENGTH;
               else begin
                  l2 = dx * dx + dz * dz;
                  if (l2 * 10000 < 65536 ||
                      l2 > longint'(pcc_pkg::SegMax) * longint'(pcc_pkg::SegMax))
                     o.status = pcc_pkg::ST_LENGTH;
                  else if (n_route >= pcc_pkg::MaxRoutes) o.status = pcc_pkg::ST_FULL;
                  else begin
                     rt_sx[n_route] = px;
                     rt_sz[n_route] = pz;
                     rt_ex[n_route] = ex;
                     rt_ez[n_route] = ez;
                     rt_hw[n_route] = sz;
                     rt_agents[n_route] = q.agent_mask;
                     n_route++;
                  end
               end
            end
            default: begin
               queries++;
               if (sz > pcc_pkg::SizeMax) o.status = pcc_pkg::ST_RANGE;
               else begin
                  ok = 1;
                  for (int i = 0; ok && i < n_excl; i++)
                     if (excl_hit(i, px, pz, sz)) ok = 0;
                  for (int i = 0; ok && i < n_route; i++)
                     if (route_hit(i, px, pz, sz)) ok = 0;
                  o.allowed = ok;
                  if (ok) clear_queries++;
               end
            end
         endcase
         o.exclusion_count = 9'(n_excl);
         o.route_count = 9'(n_route);
         status_seen[o.status]++;
         pending = {pending, o};
      endfunction

      function void check_response(pcc_pkg::rsp_type got);
         pcc_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected response %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response mismatch expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   pcc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   pcc_pkg::rsp_type rsp_data;
   logic csr_write_enable = 0;
   logic csr_index = pcc_pkg::CSR_AGENT0;
   logic [10:0] csr_write_data = '0;

   clearance_scoreboard tables = new();
   int idle_cycles = 0;
   int burst_left = 0;
   bit no_gaps = 0;
   longint centre[3];

   placement_clearance_check_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tables.note_request(req_data);
         if (rsp_valid && !rsp_stall) tables.check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WatchdogLimit) begin
         $display("ERROR: no transfer for %0d cycles", WatchdogLimit);
         $display("Verification failed");
         $finish;
      end
   end

   // receiver stall pattern: free, random, long holds
   int stall_mode = 0, stall_count = 0;
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_count = $urandom_range(20, 120);
      end
      stall_count--;
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ($urandom_range(0, 15) != 0);
      endcase
   end

   task automatic send(pcc_pkg::req_type q);
      if (!no_gaps && burst_left == 0) begin
         @(negedge clock);
         req_valid = 0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      else @(negedge clock);
      if (burst_left > 0) burst_left--;
      req_valid = 1;
      req_data = q;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (tables.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_radius(logic idx, logic [10:0] value);
      @(negedge clock);
      csr_write_enable = 1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 0;
      tables.set_radius(idx, value);
   endtask

   function automatic pcc_pkg::req_type item(logic [1:0] act, longint px, longint pz,
                                             longint ex, longint ez, int sz,
                                             logic [1:0] m);
      pcc_pkg::req_type q;
      q.action = act;
      q.point_x = 40'(px);
      q.point_z = 40'(pz);
      q.end_x = 40'(ex);
      q.end_z = 40'(ez);
      q.size_value = 15'(sz);
      q.agent_mask = m;
      return q;
   endfunction

   function automatic longint rand40();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return longint'($signed(w[39:0]));
   endfunction

   function automatic longint jitter();
      case ($urandom_range(0, 9))
         0, 1, 2: return $signed($urandom_range(0, 1200)) - 600;
         3, 4, 5: return $signed($urandom_range(0, 40000)) - 20000;
         6, 7: return $signed($urandom_range(0, 300000)) - 150000;
         default: return $signed($urandom_range(0, 1400000)) - 700000;
      endcase
   endfunction

   function automatic pcc_pkg::req_type random_item();
      longint px, pz, ex, ez, c;
      int sel, sz;
      logic [191:0] w;
      pcc_pkg::req_type q;
      sel = $urandom_range(0, 99);
      c = centre[$urandom_range(0, 2)];
      px = c + jitter();
      pz = c + jitter();
      if (sel < 6) begin
         q = item(pcc_pkg::ACT_CLEAR, rand40(), rand40(), rand40(), rand40(),
                  $urandom_range(0, 32767), 2'($urandom()));
         q.size_value = 15'($urandom());
         return q;
      end
      if (sel < 12) begin
         w = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
         q = w[$bits(pcc_pkg::req_type)-1:0];
         return q;
      end
      if (sel < 34) begin
         sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                          : $urandom_range(pcc_pkg::ExclMin, pcc_pkg::SizeMax);
         return item(pcc_pkg::ACT_EXCL, px, pz, rand40(), rand40(), sz, 2'($urandom()));
      end
      if (sel < 56) begin
         case ($urandom_range(0, 9))
            0: begin ex = px + $urandom_range(0, 3); ez = pz; end
            1: begin
               ex = px + $signed($urandom_range(0, 280000)) - 140000;
               ez = pz + $signed($urandom_range(0, 280000)) - 140000;
            end
            default: begin
               ex = px + $signed($urandom_range(0, 120000)) - 60000;
               ez = pz + $signed($urandom_range(0, 120000)) - 60000;
            end
         endcase
         sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                          : $urandom_range(0, pcc_pkg::SizeMax);
         return item(pcc_pkg::ACT_ROUTE, px, pz, ex, ez, sz,
                     ($urandom_range(0, 9) == 0) ? 2'b00 : 2'($urandom_range(1, 3)));
      end
      sz = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 32767)
                                        : $urandom_range(0, pcc_pkg::SizeMax);
      return item(pcc_pkg::ACT_QUERY, px, pz, rand40(), rand40(), sz, 2'($urandom()));
   endfunction

   localparam longint XMax = 64'sd549755813887;
   localparam longint XMin = -64'sd549755813888;

   initial begin
      tables.reset_state();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: limits and status codes
      send(item(pcc_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0));
      send(item(pcc_pkg::ACT_EXCL, 1000, 1000, 0, 0, 25, 0));
      send(item(pcc_pkg::ACT_EXCL, 1000, 1000, 0, 0, 26, 0));
      send(item(pcc_pkg::ACT_EXCL, XMax, XMin, 0, 0, 16384, 3));
      send(item(pcc_pkg::ACT_EXCL, 0, 0, 0, 0, 16385, 0));
      send(item(pcc_pkg::ACT_EXCL, 0, 0, 0, 0, 32767, 0));
      send(item(pcc_pkg::ACT_ROUTE, 0, 0, 50000, 0, 16385, 1));
      send(item(pcc_pkg::ACT_ROUTE, 0, 0, 50000, 0, 100, 0));
      send(item(pcc_pkg::ACT_ROUTE, 0, 0, 0, 0, 100, 1));
      send(item(pcc_pkg::ACT_ROUTE, 0, 0, 2, 0, 100, 1));
      send(item(pcc_pkg::ACT_ROUTE, 0, 0, 0, 3, 100, 2));
      send(item(pcc_pkg::ACT_ROUTE, 0, 0, 131073, 0, 100, 3));
      send(item(pcc_pkg::ACT_ROUTE, 0, 0, 131072, 131072, 100, 3));
      send(item(pcc_pkg::ACT_ROUTE, 0, 20000, 131072, 20000, 0, 3));
      send(item(pcc_pkg::ACT_ROUTE, XMax - 70000, XMax, XMax, XMax - 70000, 16384, 2));
      send(item(pcc_pkg::ACT_QUERY, 1000, 1000, 0, 0, 16385, 0));
      send(item(pcc_pkg::ACT_QUERY, 1000, 1000, 0, 0, 0, 0));
      send(item(pcc_pkg::ACT_QUERY, 1000 + 524289, 1000, 0, 0, 16384, 0));
      send(item(pcc_pkg::ACT_QUERY, 60000, 20000 + 150, XMax, XMin, 0, 3));
      send(item(pcc_pkg::ACT_QUERY, 60000, 20000 + 400, 0, 0, 0, 0));
      send(item(pcc_pkg::ACT_QUERY, -200, 20000, 0, 0, 0, 0));
      send(item(pcc_pkg::ACT_QUERY, 131072 + 250, 20000, 0, 0, 0, 0));
      send(item(pcc_pkg::ACT_QUERY, XMax - 35000, XMax - 35000, 0, 0, 16384, 0));
      send(item(pcc_pkg::ACT_QUERY, XMin, XMax, 0, 0, 32767, 3));
      drain();

      // full tables
      no_gaps = 1;
      for (int i = 0; i <= pcc_pkg::MaxExclusions; i++)
         send(item(pcc_pkg::ACT_EXCL, 400000 + i * 300, -400000, 0, 0, 26, 0));
      for (int i = 0; i <= pcc_pkg::MaxRoutes; i++)
         send(item(pcc_pkg::ACT_ROUTE, -300000, 300000 + i * 40, -250000, 300000, 10, 3));
      send(item(pcc_pkg::ACT_QUERY, 0, 0, 0, 0, 1000, 0));
      send(item(pcc_pkg::ACT_QUERY, -280000, 300000 + 100, 0, 0, 0, 0));
      send(item(pcc_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0));
      no_gaps = 0;
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_radius(pcc_pkg::CSR_AGENT0, 26);
               write_radius(pcc_pkg::CSR_AGENT1, 1024);
            end
            1: begin
               write_radius(pcc_pkg::CSR_AGENT0, 2047);
               write_radius(pcc_pkg::CSR_AGENT1, 0);
            end
            2: begin
               write_radius(pcc_pkg::CSR_AGENT0, 11'($urandom()));
               write_radius(pcc_pkg::CSR_AGENT1, 11'($urandom()));
            end
            default: begin
               write_radius(pcc_pkg::CSR_AGENT0, 128);
               write_radius(pcc_pkg::CSR_AGENT1, 128);
            end
         endcase
         centre[0] = rand40();
         centre[1] = (ph % 2) ? XMax - 1000 : XMin + 1000;
         centre[2] = 0;
         for (int n = 0; n < 10; n++) begin
            no_gaps = ((n / 3) % 2 == 1);
            if (n == 5) drain();
            send(random_item());
         end
         drain();
      end

      $display("Covered %0d queries (%0d clear); ok/range/full/mask/len: %0d/%0d/%0d/%0d/%0d",
               tables.queries, tables.clear_queries, tables.status_seen[0],
               tables.status_seen[1], tables.status_seen[2], tables.status_seen[3],
               tables.status_seen[4]);
      $display("Mismatches: %0d, responses left over: %0d",
               tables.mismatches, tables.pending.size());
      if (tables.mismatches == 0 && tables.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/pcc_pkg.sv
rtl/pcc_mac.sv
rtl/pcc_tables.sv
rtl/placement_clearance_check_unit.sv
dv/tb_placement_clearance_check_unit.sv
